[sv/rlct_pkg.sv]
// rlct_pkg: shared constants, codes and controller/datapath bundles
// for the run-length chunk tracker. No dependencies.
package rlct_pkg;

  localparam int MAX_RUNS   = 64;
  localparam int INDEX_BITS = 32;
  localparam int POS_BITS   = INDEX_BITS + 1;
  localparam int ADDR_BITS  = $clog2(MAX_RUNS);
  localparam int RUN_BITS   = $clog2(MAX_RUNS + 1);
  localparam int FUNC_BITS  = 2;
  localparam int TOTAL_BITS = 7;

  localparam logic [FUNC_BITS-1:0] FN_MARK    = 2'd1;
  localparam logic [FUNC_BITS-1:0] FN_RESTART = 2'd2;

  // read address source
  typedef enum logic [1:0] {RD_SCAN, RD_MOVE, RD_NEXT} rsel_t;

  // write address source
  typedef enum logic [2:0] {
    WA_ZERO, WA_ONE, WA_KM1, WA_K, WA_KP1, WA_KP2, WA_N
  } wasel_t;

  // write data source
  typedef enum logic [3:0] {
    WD_ZERO, WD_TOTAL, WD_PREV_INC, WD_PREV_MERGE, WD_LEN_DEC,
    WD_ONE, WD_NEXT_INC, WD_OFF, WD_TAIL
  } wdsel_t;

  // run count update
  typedef enum logic [2:0] {
    NC_KEEP, NC_SET2, NC_DEC1, NC_DEC2, NC_INC1, NC_INC2
  } ncnt_t;

  typedef struct packed {
    logic   load;
    logic   scan_run;
    rsel_t  rsel;
    logic   wr;
    wasel_t wa;
    wdsel_t wd;
    logic   mv_start;
    logic   mv_up;
    ncnt_t  nop;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
    logic found;
    logic k_odd;
    logic off_zero;
    logic len_one;
    logic off_last;
    logic has_next;
    logic room1;
    logic room2;
    logic mv_busy;
  } stat_t;

endpackage

[sv/rlct_req_if.sv]
// rlct_req_if: request channel of the chunk tracker
// depends on rlct_pkg
interface rlct_req_if import rlct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_BITS-1:0]  func;
  logic [INDEX_BITS-1:0] chunk_index;

  modport source (output valid, func, chunk_index, input ready);
  modport sink   (input valid, func, chunk_index, output ready);
endinterface

[sv/rlct_res_if.sv]
// rlct_res_if: result channel of the chunk tracker
// depends on rlct_pkg
interface rlct_res_if import rlct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  held;
  logic                  rejected;
  logic [TOTAL_BITS-1:0] run_total;

  modport source (output valid, held, rejected, run_total, input ready);
  modport sink   (input valid, held, rejected, run_total, output ready);
endinterface

[sv/rlct_dpath.sv]
// rlct_dpath: run length memory, scan accumulator and shift engine
// depends on rlct_pkg; driven by rlct_ctrl through cmd_t / stat_t
module rlct_dpath import rlct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [INDEX_BITS-1:0] in_index,
  input  logic                  cfg_we,
  input  logic [INDEX_BITS-1:0] cfg_data,
  output logic [RUN_BITS-1:0]   run_cnt
);

  logic [INDEX_BITS-1:0] mem [MAX_RUNS];
  logic [INDEX_BITS-1:0] rd_q;

  logic [INDEX_BITS-1:0] total_r, idx_r, prev_r, len_r, off_r;
  logic [POS_BITS-1:0]   pos_r;
  logic [RUN_BITS-1:0]   n_r, k_r, ra_r, dk_r;
  logic                  dv_r, found_r;
  logic [RUN_BITS-1:0]   mv_src_r, mv_cnt_r, mw_a_r;
  logic                  mv_up_r, mw_v_r;

  logic [RUN_BITS-1:0]   km1, kp1, kp2, wa_full;
  logic [ADDR_BITS-1:0]  raddr, waddr;
  logic [INDEX_BITS-1:0] wdata;
  logic                  we;
  logic [POS_BITS-1:0]   pos_end;
  logic                  ent_in, hit_now, miss_now;

  assign km1 = k_r - RUN_BITS'(1);
  assign kp1 = k_r + RUN_BITS'(1);
  assign kp2 = k_r + RUN_BITS'(2);

  // scan compare
  assign ent_in   = dk_r < n_r;
  assign pos_end  = pos_r + {1'b0, rd_q};
  assign hit_now  = cmd.scan_run && dv_r && ent_in && ({1'b0, idx_r} < pos_end);
  assign miss_now = cmd.scan_run && dv_r && !ent_in;

  always_comb begin
    case (cmd.rsel)
      RD_SCAN: raddr = ra_r[ADDR_BITS-1:0];
      RD_MOVE: raddr = mv_src_r[ADDR_BITS-1:0];
      RD_NEXT: raddr = kp1[ADDR_BITS-1:0];
      default: raddr = ra_r[ADDR_BITS-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wa)
      WA_ZERO: wa_full = '0;
      WA_ONE:  wa_full = RUN_BITS'(1);
      WA_KM1:  wa_full = km1;
      WA_K:    wa_full = k_r;
      WA_KP1:  wa_full = kp1;
      WA_KP2:  wa_full = kp2;
      WA_N:    wa_full = n_r;
      default: wa_full = k_r;
    endcase
  end

  always_comb begin
    if (mw_v_r) begin
      we    = 1'b1;
      waddr = mw_a_r[ADDR_BITS-1:0];
      wdata = rd_q;
    end else begin
      we    = cmd.wr;
      waddr = wa_full[ADDR_BITS-1:0];
      case (cmd.wd)
        WD_ZERO:       wdata = '0;
        WD_TOTAL:      wdata = total_r;
        WD_PREV_INC:   wdata = prev_r + INDEX_BITS'(1);
        WD_PREV_MERGE: wdata = prev_r + rd_q + INDEX_BITS'(1);
        WD_LEN_DEC:    wdata = len_r - INDEX_BITS'(1);
        WD_ONE:        wdata = INDEX_BITS'(1);
        WD_NEXT_INC:   wdata = rd_q + INDEX_BITS'(1);
        WD_OFF:        wdata = off_r;
        WD_TAIL:       wdata = len_r - off_r - INDEX_BITS'(1);
        default:       wdata = '0;
      endcase
    end
  end

  // run length store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.load) begin
      idx_r   <= in_index;
      pos_r   <= '0;
      ra_r    <= '0;
      dv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_run) begin
      ra_r <= ra_r + RUN_BITS'(1);
      dk_r <= ra_r;
      dv_r <= 1'b1;
      if (hit_now) begin
        found_r <= 1'b1;
        k_r     <= dk_r;
        len_r   <= rd_q;
        off_r   <= idx_r - pos_r[INDEX_BITS-1:0];
      end else if (dv_r && ent_in) begin
        pos_r  <= pos_end;
        prev_r <= rd_q;
      end
    end
  end

  // shift engine: one entry moved by two places per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_cnt_r <= '0;
      mw_v_r   <= 1'b0;
    end else if (cmd.mv_start) begin
      mv_up_r <= cmd.mv_up;
      mw_v_r  <= 1'b0;
      if (cmd.mv_up) begin
        mv_src_r <= n_r - RUN_BITS'(1);
        mv_cnt_r <= n_r - k_r - RUN_BITS'(1);
      end else begin
        mv_src_r <= kp2;
        mv_cnt_r <= n_r - k_r - RUN_BITS'(2);
      end
    end else if (mv_cnt_r != '0) begin
      mv_cnt_r <= mv_cnt_r - RUN_BITS'(1);
      mw_v_r   <= 1'b1;
      if (mv_up_r) begin
        mv_src_r <= mv_src_r - RUN_BITS'(1);
        mw_a_r   <= mv_src_r + RUN_BITS'(2);
      end else begin
        mv_src_r <= mv_src_r + RUN_BITS'(1);
        mw_a_r   <= mv_src_r - RUN_BITS'(2);
      end
    end else begin
      mw_v_r <= 1'b0;
    end
  end

  // run count and transfer size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= RUN_BITS'(2);
      total_r <= '0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_data;
      end
      case (cmd.nop)
        NC_SET2: n_r <= RUN_BITS'(2);
        NC_DEC1: n_r <= n_r - RUN_BITS'(1);
        NC_DEC2: n_r <= n_r - RUN_BITS'(2);
        NC_INC1: n_r <= n_r + RUN_BITS'(1);
        NC_INC2: n_r <= n_r + RUN_BITS'(2);
        default: n_r <= n_r;
      endcase
    end
  end

  always_comb begin
    stat.scan_hit  = hit_now;
    stat.scan_miss = miss_now;
    stat.found     = found_r;
    stat.k_odd     = k_r[0];
    stat.off_zero  = off_r == '0;
    stat.len_one   = len_r == INDEX_BITS'(1);
    stat.off_last  = off_r == (len_r - INDEX_BITS'(1));
    stat.has_next  = kp1 < n_r;
    stat.room1     = n_r < RUN_BITS'(MAX_RUNS);
    stat.room2     = n_r <= RUN_BITS'(MAX_RUNS - 2);
    stat.mv_busy   = (mv_cnt_r != '0) || mw_v_r;
  end

  assign run_cnt = n_r;

endmodule

[sv/rlct_ctrl.sv]
// rlct_ctrl: sequencer for scan, run edits and list reload
// depends on rlct_pkg; drives rlct_dpath through cmd_t / stat_t
module rlct_ctrl import rlct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [FUNC_BITS-1:0] in_func,
  output logic                 in_ready,
  output cmd_t                 cmd,
  input  stat_t                stat,
  input  logic                 out_free,
  output logic                 res_valid,
  output logic                 res_held,
  output logic                 res_rej
);

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_SCAN, S_DECIDE,
    S_A1_RD, S_A1_WR, S_RM_MOVE, S_A2_WR, S_A3_WR0, S_A3_WR1,
    S_B1_WR0, S_B1_WR1, S_B2_WR0, S_B2_WR1,
    S_C_MOVE, S_C_WR0, S_C_WR1, S_C_WR2, S_FINISH
  } state_t;

  state_t               state_r, state_nxt;
  logic [FUNC_BITS-1:0] func_r, func_nxt;
  logic                 restart_r, restart_nxt;
  logic                 held_r, held_nxt;
  logic                 rej_r, rej_nxt;

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    restart_nxt = restart_r;
    held_nxt    = held_r;
    rej_nxt     = rej_r;
    cmd         = '0;
    cmd.rsel    = RD_SCAN;
    cmd.wa      = WA_K;
    cmd.wd      = WD_ZERO;
    cmd.nop     = NC_KEEP;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    unique case (state_r)
      S_INIT0: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_ZERO;
        cmd.wd    = WD_ZERO;
        state_nxt = S_INIT1;
      end
      S_INIT1: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_ONE;
        cmd.wd    = WD_TOTAL;
        cmd.nop   = NC_SET2;
        held_nxt  = 1'b0;
        rej_nxt   = 1'b0;
        state_nxt = restart_r ? S_FINISH : S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          func_nxt    = in_func;
          held_nxt    = 1'b0;
          rej_nxt     = 1'b0;
          restart_nxt = in_func == FN_RESTART;
          state_nxt   = (in_func == FN_RESTART) ? S_INIT0 : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_hit || stat.scan_miss) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (func_r != FN_MARK || !stat.found || !stat.k_odd) begin
          held_nxt  = stat.found && !stat.k_odd;
          state_nxt = S_FINISH;
        end else begin
          held_nxt = 1'b1;
          if (stat.off_zero) begin
            if (stat.len_one) begin
              state_nxt = stat.has_next ? S_A1_RD : S_A2_WR;
            end else begin
              state_nxt = S_A3_WR0;
            end
          end else if (stat.off_last) begin
            if (stat.has_next) begin
              state_nxt = S_B1_WR0;
            end else if (stat.room1) begin
              state_nxt = S_B2_WR0;
            end else begin
              held_nxt  = 1'b0;
              rej_nxt   = 1'b1;
              state_nxt = S_FINISH;
            end
          end else if (stat.room2) begin
            cmd.mv_start = 1'b1;
            cmd.mv_up    = 1'b1;
            state_nxt    = S_C_MOVE;
          end else begin
            held_nxt  = 1'b0;
            rej_nxt   = 1'b1;
            state_nxt = S_FINISH;
          end
        end
      end
      // missing run of one between two received runs
      S_A1_RD: begin
        cmd.rsel  = RD_NEXT;
        state_nxt = S_A1_WR;
      end
      S_A1_WR: begin
        cmd.wr       = 1'b1;
        cmd.wa       = WA_KM1;
        cmd.wd       = WD_PREV_MERGE;
        cmd.mv_start = 1'b1;
        cmd.mv_up    = 1'b0;
        state_nxt    = S_RM_MOVE;
      end
      S_RM_MOVE: begin
        cmd.rsel = RD_MOVE;
        if (!stat.mv_busy) begin
          cmd.nop   = NC_DEC2;
          state_nxt = S_FINISH;
        end
      end
      // last missing run of one
      S_A2_WR: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_KM1;
        cmd.wd    = WD_PREV_INC;
        cmd.nop   = NC_DEC1;
        state_nxt = S_FINISH;
      end
      // head of a longer missing run
      S_A3_WR0: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_KM1;
        cmd.wd    = WD_PREV_INC;
        state_nxt = S_A3_WR1;
      end
      S_A3_WR1: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_K;
        cmd.wd    = WD_LEN_DEC;
        state_nxt = S_FINISH;
      end
      // tail of a missing run, received run follows
      S_B1_WR0: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_K;
        cmd.wd    = WD_LEN_DEC;
        cmd.rsel  = RD_NEXT;
        state_nxt = S_B1_WR1;
      end
      S_B1_WR1: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_KP1;
        cmd.wd    = WD_NEXT_INC;
        state_nxt = S_FINISH;
      end
      // tail of the last run, new received run appended
      S_B2_WR0: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_K;
        cmd.wd    = WD_LEN_DEC;
        state_nxt = S_B2_WR1;
      end
      S_B2_WR1: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_N;
        cmd.wd    = WD_ONE;
        cmd.nop   = NC_INC1;
        state_nxt = S_FINISH;
      end
      // split inside a missing run
      S_C_MOVE: begin
        cmd.rsel = RD_MOVE;
        if (!stat.mv_busy) begin
          state_nxt = S_C_WR0;
        end
      end
      S_C_WR0: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_K;
        cmd.wd    = WD_OFF;
        state_nxt = S_C_WR1;
      end
      S_C_WR1: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_KP1;
        cmd.wd    = WD_ONE;
        state_nxt = S_C_WR2;
      end
      S_C_WR2: begin
        cmd.wr    = 1'b1;
        cmd.wa    = WA_KP2;
        cmd.wd    = WD_TAIL;
        cmd.nop   = NC_INC2;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT0;
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      restart_r <= restart_nxt;
    end
    func_r <= func_nxt;
    held_r <= held_nxt;
    rej_r  <= rej_nxt;
  end

  assign res_held = held_r;
  assign res_rej  = rej_r;

endmodule

[sv/run_length_chunk_tracker_unit.sv]
// run_length_chunk_tracker_unit: chunk arrival tracker kept as a list of
// alternating received / missing run lengths.
// Requests enter on in_ch (func, chunk_index): query, mark received or
// restart the list from total_chunks. Each request gives one result on
// out_ch: held, rejected and the run count afterwards.
// total_chunks is loaded through cfg_we / cfg_data and is read by a restart
// and by the list setup after reset.
// A query or mark walks the run memory one entry per cycle. A mark that
// merges two runs or splits one also shifts the tail of the list one entry
// per cycle.
// One request is worked on at a time; in_ch.ready is high only between
// requests.
// After reset the list {0, 0} is written with in_ch.ready low.
// Results sit in an output register: the next request is taken while a
// result waits, and a stalled receiver holds the block only once a second
// result is ready.
// depends on rlct_pkg, rlct_req_if, rlct_res_if, rlct_ctrl, rlct_dpath
module run_length_chunk_tracker_unit import rlct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rlct_req_if.sink              in_ch,
  rlct_res_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [INDEX_BITS-1:0] cfg_data
);

  cmd_t                cmd;
  stat_t               stat;
  logic [RUN_BITS-1:0] run_cnt;
  logic                out_free, res_valid, res_held, res_rej;

  logic                out_valid_r, held_r, rej_r;
  logic [RUN_BITS-1:0] tot_r;

  rlct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_held  (res_held),
    .res_rej   (res_rej)
  );

  rlct_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_index (in_ch.chunk_index),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .run_cnt  (run_cnt)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      held_r <= res_held;
      rej_r  <= res_rej;
      tot_r  <= run_cnt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.held      = held_r;
  assign out_ch.rejected  = rej_r;
  assign out_ch.run_total = TOTAL_BITS'(tot_r);

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in progress");

  a_rej_not_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> !held_r)
    else $error("rejected mark reports chunk held");

  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> (tot_r >= RUN_BITS'(MAX_RUNS - 1)))
    else $error("mark rejected with room left in run list");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (tot_r != '0 && tot_r <= RUN_BITS'(MAX_RUNS)))
    else $error("run count out of range");

endmodule
